// ===== src/loop_utilization_monitor_defines.svh =====
// assertion helpers for the loop utilization monitor
`ifndef LOOP_UTILIZATION_MONITOR_DEFINES_SVH
`define LOOP_UTILIZATION_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define LUM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define LUM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define LUM_ASSERT_NOW(lbl, ante, cons)
`define LUM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/lum_pkg.sv =====
package lum_pkg;

  localparam int HISTORY_DEPTH = 60;
  localparam int RING_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  localparam int USAGE_FULL = 1000;
  localparam int MS_PER_S = 1000;

  // shared divider: numerator left-aligned in DIV_NW bits, one quotient bit per cycle
  localparam int DIV_NW = 42;
  localparam int DIV_DW = 32;
  localparam int STEP_W = $clog2(DIV_NW + 1);

  localparam int USAGE_STEPS = 33;
  localparam int RATE_STEPS = 42;
  localparam int AVG_STEPS = 32;
  localparam int HIST_STEPS = 17;

  typedef struct packed {
    logic [31:0] busy_us;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic        window_closed;
    logic [9:0]  usage_tenths;
    logic [9:0]  usage_avg_tenths;
    logic [9:0]  usage_peak_tenths;
    logic [31:0] loop_rate_hz;
    logic [31:0] loop_avg_us;
    logic [31:0] loop_max_us;
    logic [31:0] loop_max_ever_us;
    logic [5:0]  history_fill;
  } stats_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_sts_t;

  typedef enum logic [3:0] {
    LUM_IDLE,
    LUM_USAGE,
    LUM_USAGE_WAIT,
    LUM_RATE,
    LUM_RATE_WAIT,
    LUM_AVG,
    LUM_AVG_WAIT,
    LUM_RING,
    LUM_HIST,
    LUM_HIST_WAIT,
    LUM_DONE
  } lum_state_t;

endpackage

// ===== src/lum_ifs.sv =====
interface lum_sample_if;
  logic              valid;
  logic              ready;
  lum_pkg::sample_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lum_stats_if;
  logic             valid;
  logic             ready;
  lum_pkg::stats_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lum_div.sv =====
module lum_div (
  input  logic              clk,
  input  logic              rst,
  input  lum_pkg::div_req_t req,
  output lum_pkg::div_sts_t sts
);

  logic                              busy;
  logic [lum_pkg::STEP_W-1:0]        cnt;
  logic [lum_pkg::DIV_DW-1:0]        rem;
  logic [lum_pkg::DIV_DW-1:0]        den;
  logic [lum_pkg::DIV_NW-1:0]        quo;
  logic [lum_pkg::DIV_DW:0]          rem_sh;
  logic                              ge;
  logic [lum_pkg::DIV_DW:0]          rem_sub;

  // restoring step: bring down the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem, quo[lum_pkg::DIV_NW-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      quo <= req.num;
    end else if (busy && cnt != '0) begin
      rem <= ge ? rem_sub[lum_pkg::DIV_DW-1:0] : rem_sh[lum_pkg::DIV_DW-1:0];
      quo <= {quo[lum_pkg::DIV_NW-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = busy && (cnt == '0);
  assign sts.quo  = quo;

endmodule

// ===== src/loop_utilization_monitor.sv =====
// Loop utilization monitor. Every sample (busy_us, now_ms) gives one stats transaction.
// A sample that does not close a window goes from idle straight to the done state; its
// result is loaded into the output register there once that register is free, and no new
// sample is taken before then. A sample that closes a window runs four divisions on one
// shared radix-2 divider (usage 33 steps, loop rate 42, average 32, history average 17)
// and one history ring update; the result is loaded into the output register in the done
// state, and the next sample is taken only after that load, which waits while the output
// register is held. The window length in ms is written on cfg_we; a value of 0 acts as 1 ms.
`include "loop_utilization_monitor_defines.svh"

module loop_utilization_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  lum_sample_if.sink  sample,
  lum_stats_if.source stats
);

  lum_pkg::lum_state_t state, state_next;
  lum_pkg::div_req_t   div_req;
  lum_pkg::div_sts_t   div_sts;

  logic [15:0] cfg_len_ms;
  logic        window_open;
  logic [31:0] window_start;
  logic [31:0] window_busy;
  logic [31:0] window_count;
  logic [31:0] window_peak;
  logic [9:0]  last_usage;
  logic [9:0]  peak_usage;
  logic [31:0] last_rate;
  logic [31:0] last_average;
  logic [31:0] last_window_peak;
  logic [31:0] overall_peak;
  logic [9:0]  hist_avg;
  logic        closed;
  logic [31:0] elapsed;

  logic [9:0]                  usage_ring [lum_pkg::HISTORY_DEPTH];
  logic [9:0]                  ring_rdata;
  logic [lum_pkg::FILL_W-1:0]  ring_fill;
  logic [lum_pkg::RING_AW-1:0] ring_write_pos;
  logic [15:0]                 ring_total;

  logic        out_valid;
  lum_pkg::stats_t out_data;

  logic        accept;
  logic [31:0] start_eff;
  logic [32:0] busy_sum;
  logic [31:0] busy_sat;
  logic [31:0] elapsed_now;
  logic [15:0] win_len;
  logic        closes;
  logic [32:0] usage_num;
  logic [16:0] hist_num;
  logic [9:0]  usage_q;
  logic        ring_full;

  lum_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .sts (div_sts)
  );

  assign accept = sample.valid && sample.ready;

  always_comb begin
    start_eff   = window_open ? window_start : sample.data.now_ms;
    busy_sum    = {1'b0, window_busy} + {1'b0, sample.data.busy_us};
    busy_sat    = busy_sum[32] ? '1 : busy_sum[31:0];
    elapsed_now = sample.data.now_ms - start_eff;
    win_len     = (cfg_len_ms == '0) ? 16'd1 : cfg_len_ms;
    closes      = elapsed_now >= {16'b0, win_len};
    usage_num   = {1'b0, window_busy} + {2'b0, elapsed[31:1]};
    hist_num    = 17'(ring_total) + 17'(ring_fill >> 1);
    usage_q     = (div_sts.quo > lum_pkg::DIV_NW'(lum_pkg::USAGE_FULL)) ?
                  10'(lum_pkg::USAGE_FULL) : div_sts.quo[9:0];
    ring_full   = ring_fill >= lum_pkg::FILL_W'(lum_pkg::HISTORY_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lum_pkg::LUM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_req      = '0;
    sample.ready = 1'b0;
    case (state)
      lum_pkg::LUM_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = closes ? lum_pkg::LUM_USAGE : lum_pkg::LUM_DONE;
        end
      end
      lum_pkg::LUM_USAGE: begin
        div_req.start = 1'b1;
        div_req.num   = lum_pkg::DIV_NW'(usage_num)
                        << (lum_pkg::DIV_NW - lum_pkg::USAGE_STEPS);
        div_req.den   = elapsed;
        div_req.steps = lum_pkg::STEP_W'(lum_pkg::USAGE_STEPS);
        state_next    = lum_pkg::LUM_USAGE_WAIT;
      end
      lum_pkg::LUM_USAGE_WAIT: begin
        if (div_sts.done) begin
          state_next = lum_pkg::LUM_RATE;
        end
      end
      lum_pkg::LUM_RATE: begin
        div_req.start = 1'b1;
        div_req.num   = (lum_pkg::DIV_NW'(window_count)
                         * lum_pkg::DIV_NW'(lum_pkg::MS_PER_S))
                        << (lum_pkg::DIV_NW - lum_pkg::RATE_STEPS);
        div_req.den   = elapsed;
        div_req.steps = lum_pkg::STEP_W'(lum_pkg::RATE_STEPS);
        state_next    = lum_pkg::LUM_RATE_WAIT;
      end
      lum_pkg::LUM_RATE_WAIT: begin
        if (div_sts.done) begin
          state_next = lum_pkg::LUM_AVG;
        end
      end
      lum_pkg::LUM_AVG: begin
        div_req.start = 1'b1;
        div_req.num   = lum_pkg::DIV_NW'(window_busy)
                        << (lum_pkg::DIV_NW - lum_pkg::AVG_STEPS);
        div_req.den   = window_count;
        div_req.steps = lum_pkg::STEP_W'(lum_pkg::AVG_STEPS);
        state_next    = lum_pkg::LUM_AVG_WAIT;
      end
      lum_pkg::LUM_AVG_WAIT: begin
        if (div_sts.done) begin
          state_next = lum_pkg::LUM_RING;
        end
      end
      lum_pkg::LUM_RING: begin
        state_next = lum_pkg::LUM_HIST;
      end
      lum_pkg::LUM_HIST: begin
        div_req.start = 1'b1;
        div_req.num   = lum_pkg::DIV_NW'(hist_num)
                        << (lum_pkg::DIV_NW - lum_pkg::HIST_STEPS);
        div_req.den   = lum_pkg::DIV_DW'(ring_fill);
        div_req.steps = lum_pkg::STEP_W'(lum_pkg::HIST_STEPS);
        state_next    = lum_pkg::LUM_HIST_WAIT;
      end
      lum_pkg::LUM_HIST_WAIT: begin
        if (div_sts.done) begin
          state_next = lum_pkg::LUM_DONE;
        end
      end
      lum_pkg::LUM_DONE: begin
        if (!out_valid || stats.ready) begin
          state_next = lum_pkg::LUM_IDLE;
        end
      end
      default: begin
        state_next = lum_pkg::LUM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len_ms <= 16'd1000;
    end else if (cfg_we) begin
      cfg_len_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_open      <= 1'b0;
      window_start     <= '0;
      window_busy      <= '0;
      window_count     <= '0;
      window_peak      <= '0;
      last_usage       <= '0;
      peak_usage       <= '0;
      last_rate        <= '0;
      last_average     <= '0;
      last_window_peak <= '0;
      overall_peak     <= '0;
      hist_avg         <= '0;
      closed           <= 1'b0;
      elapsed          <= '0;
      ring_fill        <= '0;
      ring_write_pos   <= '0;
      ring_total       <= '0;
    end else begin
      case (state)
        lum_pkg::LUM_IDLE: begin
          if (accept) begin
            window_open  <= 1'b1;
            window_start <= closes ? sample.data.now_ms : start_eff;
            window_busy  <= busy_sat;
            if (window_count != '1) begin
              window_count <= window_count + 32'd1;
            end
            if (sample.data.busy_us > window_peak) begin
              window_peak <= sample.data.busy_us;
            end
            if (sample.data.busy_us > overall_peak) begin
              overall_peak <= sample.data.busy_us;
            end
            closed  <= closes;
            elapsed <= elapsed_now;
          end
        end
        lum_pkg::LUM_USAGE_WAIT: begin
          if (div_sts.done) begin
            last_usage <= usage_q;
            if (usage_q > peak_usage) begin
              peak_usage <= usage_q;
            end
          end
        end
        lum_pkg::LUM_RATE_WAIT: begin
          if (div_sts.done) begin
            last_rate <= (div_sts.quo[lum_pkg::DIV_NW-1:32] != '0) ?
                         '1 : div_sts.quo[31:0];
          end
        end
        lum_pkg::LUM_AVG_WAIT: begin
          if (div_sts.done) begin
            last_average     <= div_sts.quo[31:0];
            last_window_peak <= window_peak;
          end
        end
        lum_pkg::LUM_RING: begin
          // full ring: the overwritten entry leaves the running sum
          if (ring_full) begin
            ring_total <= ring_total - 16'(ring_rdata) + 16'(last_usage);
          end else begin
            ring_fill  <= ring_fill + 1'b1;
            ring_total <= ring_total + 16'(last_usage);
          end
          ring_write_pos <= (ring_write_pos == lum_pkg::RING_AW'(lum_pkg::HISTORY_DEPTH - 1)) ?
                            '0 : ring_write_pos + 1'b1;
          window_busy  <= '0;
          window_count <= '0;
          window_peak  <= '0;
        end
        lum_pkg::LUM_HIST_WAIT: begin
          if (div_sts.done) begin
            hist_avg <= div_sts.quo[9:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // history ring, read data registered; the write position is stable until the ring step
  always_ff @(posedge clk) begin
    if (state == lum_pkg::LUM_RING) begin
      usage_ring[ring_write_pos] <= last_usage;
    end
    ring_rdata <= usage_ring[ring_write_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lum_pkg::LUM_DONE && (!out_valid || stats.ready)) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lum_pkg::LUM_DONE && (!out_valid || stats.ready)) begin
      out_data.window_closed     <= closed;
      out_data.usage_tenths      <= last_usage;
      // empty history only before the first close, when last usage is still zero
      out_data.usage_avg_tenths  <= hist_avg;
      out_data.usage_peak_tenths <= peak_usage;
      out_data.loop_rate_hz      <= last_rate;
      out_data.loop_avg_us       <= last_average;
      out_data.loop_max_us       <= last_window_peak;
      out_data.loop_max_ever_us  <= overall_peak;
      out_data.history_fill      <= 6'(ring_fill);
    end
  end

  assign stats.valid = out_valid;
  assign stats.data  = out_data;

  `LUM_ASSERT_NOW(a_ready_div_idle, sample.ready, !div_sts.busy)
  `LUM_ASSERT_NOW(a_fill_bound, 1'b1, ring_fill <= lum_pkg::FILL_W'(lum_pkg::HISTORY_DEPTH))
  `LUM_ASSERT_NOW(a_usage_bound, 1'b1, last_usage <= 10'(lum_pkg::USAGE_FULL))
  `LUM_ASSERT_NOW(a_avg_bound, 1'b1, hist_avg <= 10'(lum_pkg::USAGE_FULL))
  `LUM_ASSERT_NEXT(a_close_starts_div, accept && closes, state == lum_pkg::LUM_USAGE)

endmodule

// ===== dv/tb.sv =====
module tb;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  lum_sample_if sample_ch ();
  lum_stats_if  stats_ch ();

  loop_utilization_monitor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .stats     (stats_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // utilization predictor state
  logic [15:0] win_len_ms     = 16'd1000;
  logic        open_flag      = 1'b0;
  logic [31:0] win_start_ms   = '0;
  logic [31:0] win_busy_sum   = '0;
  logic [31:0] win_iter_count = '0;
  logic [31:0] win_max_us     = '0;
  logic [9:0]  usage_last     = '0;
  logic [9:0]  usage_peak     = '0;
  logic [31:0] rate_last      = '0;
  logic [31:0] avg_last       = '0;
  logic [31:0] win_max_last   = '0;
  logic [31:0] max_ever_us    = '0;
  logic [9:0]  usage_hist [lum_pkg::HISTORY_DEPTH];
  int          hist_fill      = 0;
  int          hist_wr_idx    = 0;
  logic [15:0] hist_sum       = '0;

  lum_pkg::sample_t pending_samples [$];
  lum_pkg::stats_t  expected_stats [$];

  logic [31:0] stim_now_ms = '0;
  int error_count = 0;
  int samples_accepted = 0;
  int results_seen = 0;
  int closes_predicted = 0;
  int hist_overwrites = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic send_gap;

  task automatic account_sample(input lum_pkg::sample_t s);
    logic [31:0] len;
    logic [31:0] elapsed;
    logic [32:0] sum;
    logic [63:0] e;
    logic [63:0] u;
    logic [63:0] r;
    lum_pkg::stats_t want;
    logic        closed;
    len = (win_len_ms == 16'd0) ? 32'd1 : {16'd0, win_len_ms};
    closed = 1'b0;
    if (!open_flag) begin
      open_flag = 1'b1;
      win_start_ms = s.now_ms;
    end
    sum = {1'b0, win_busy_sum} + {1'b0, s.busy_us};
    win_busy_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (win_iter_count != 32'hFFFF_FFFF) win_iter_count++;
    if (s.busy_us > win_max_us) win_max_us = s.busy_us;
    if (s.busy_us > max_ever_us) max_ever_us = s.busy_us;
    elapsed = s.now_ms - win_start_ms;
    if (elapsed >= len) begin
      closed = 1'b1;
      closes_predicted++;
      e = {32'd0, elapsed};
      // usage rounds halves up, then clamps at full scale
      u = ({32'd0, win_busy_sum} + e / 2) / e;
      if (u > 64'(lum_pkg::USAGE_FULL)) u = 64'(lum_pkg::USAGE_FULL);
      usage_last = u[9:0];
      if (usage_last > usage_peak) usage_peak = usage_last;
      r = ({32'd0, win_iter_count} * 64'd1000) / e;
      rate_last = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
      avg_last = (win_iter_count != 0) ? win_busy_sum / win_iter_count : 32'd0;
      win_max_last = win_max_us;
      if (hist_fill >= lum_pkg::HISTORY_DEPTH) begin
        hist_sum = hist_sum - 16'(usage_hist[hist_wr_idx]);
        hist_overwrites++;
      end else begin
        hist_fill++;
      end
      usage_hist[hist_wr_idx] = usage_last;
      hist_sum = hist_sum + 16'(usage_last);
      hist_wr_idx = (hist_wr_idx + 1) % lum_pkg::HISTORY_DEPTH;
      win_start_ms = s.now_ms;
      win_busy_sum = '0;
      win_iter_count = '0;
      win_max_us = '0;
    end
    want.window_closed = closed;
    want.usage_tenths = usage_last;
    want.usage_avg_tenths = (hist_fill != 0) ?
        10'((int'(hist_sum) + hist_fill / 2) / hist_fill) : usage_last;
    want.usage_peak_tenths = usage_peak;
    want.loop_rate_hz = rate_last;
    want.loop_avg_us = avg_last;
    want.loop_max_us = win_max_last;
    want.loop_max_ever_us = max_ever_us;
    want.history_fill = 6'(hist_fill);
    expected_stats.push_back(want);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic compare_stats(input lum_pkg::stats_t want, input lum_pkg::stats_t got);
    check_field("window_closed", 32'(want.window_closed), 32'(got.window_closed));
    check_field("usage_tenths", 32'(want.usage_tenths), 32'(got.usage_tenths));
    check_field("usage_avg_tenths", 32'(want.usage_avg_tenths),
                32'(got.usage_avg_tenths));
    check_field("usage_peak_tenths", 32'(want.usage_peak_tenths),
                32'(got.usage_peak_tenths));
    check_field("loop_rate_hz", want.loop_rate_hz, got.loop_rate_hz);
    check_field("loop_avg_us", want.loop_avg_us, got.loop_avg_us);
    check_field("loop_max_us", want.loop_max_us, got.loop_max_us);
    check_field("loop_max_ever_us", want.loop_max_ever_us, got.loop_max_ever_us);
    check_field("history_fill", 32'(want.history_fill), 32'(got.history_fill));
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        account_sample(sample_ch.data);
        samples_accepted++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        // no gaps for a stretch in the middle of the run
        send_gap = (samples_accepted < 260 || samples_accepted >= 340) &&
                   ($urandom_range(0, 99) < 29);
        if (pending_samples.size() != 0 && !send_gap) begin
          sample_ch.data <= pending_samples.pop_front();
          sample_ch.valid <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // stats monitor
  always @(posedge clk) begin
    if (rst) begin
      stats_ch.ready <= 1'b0;
    end else begin
      if (stats_ch.valid && stats_ch.ready) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          $error("stats transaction with no sample waiting for it");
          error_count++;
        end else begin
          compare_stats(expected_stats.pop_front(), stats_ch.data);
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_seen >= 180) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        stats_ch.ready <= 1'b0;
      end else if (results_seen >= 260 && results_seen < 340) begin
        stats_ch.ready <= 1'b1;
      end else begin
        stats_ch.ready <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  task automatic push_sample(input logic [31:0] busy, input logic [31:0] now);
    lum_pkg::sample_t s;
    s.busy_us = busy;
    s.now_ms = now;
    pending_samples.push_back(s);
  endtask

  task automatic queue_random_samples(input int count);
    int unsigned span;
    int unsigned step;
    int unsigned busy;
    int pick;
    span = (win_len_ms == 16'd0) ? 1 : win_len_ms;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) step = $urandom_range(0, (span / 4 == 0) ? 1 : span / 4);
      else if (pick < 90) step = $urandom_range(span / 2, 2 * span);
      else if (pick < 95) step = $urandom;
      else step = 32'hFFFF_FFFF - $urandom_range(0, span);  // backwards, wraps
      stim_now_ms += step;
      pick = $urandom_range(0, 99);
      if (pick < 75) busy = $urandom_range(0, span * 400);
      else if (pick < 90) busy = $urandom;
      else if (pick < 95) busy = 0;
      else busy = 32'hFFFF_FFFF;
      push_sample(busy, stim_now_ms);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_stats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [15:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    win_len_ms = len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] len_list [5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    stats_ch.ready = 1'b0;
    len_list = '{16'd10, 16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 65534))};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset window length of 1000 ms
    push_sample(32'd0, 32'd0);                   // first sample opens at time zero
    push_sample(32'hFFFF_FFFF, 32'd10);          // busy sum reaches all ones; the next sample saturates it
    push_sample(32'd7, 32'd20);
    push_sample(32'h8000_0000, 32'd999);
    push_sample(32'd123, 32'd1000);              // closes exactly at length, usage clamped
    push_sample(32'd250, 32'd1400);
    push_sample(32'd250, 32'd2000);              // half a tenth rounds up
    push_sample(32'd249, 32'd2500);
    push_sample(32'd250, 32'd3000);              // just below half rounds down
    push_sample(32'd0, 32'd3999);
    push_sample(32'd0, 32'd4000);                // idle window
    push_sample(32'd1000, 32'hFFFF_FC00);        // big forward jump
    push_sample(32'd5, 32'hFFFF_FE00);
    push_sample(32'd999_999, 32'h0000_01E8);     // elapsed across timestamp wrap
    push_sample(32'd0, 32'd0);
    push_sample(32'd1, 32'd0);                   // zero elapsed, stays open
    push_sample(32'hFFFF_FFFF, 32'd1000);
    push_sample(32'h5555_5555, 32'd1500);
    push_sample(32'hAAAA_AAAA, 32'd2000);        // sum lands exactly on all ones
    push_sample(32'd0, 32'd2999);
    push_sample(32'd0, 32'd3000);
    stim_now_ms = 32'd3000;
    wait_drained();

    foreach (len_list[i]) begin
      write_window_len(len_list[i]);
      queue_random_samples(76);
      wait_drained();
    end

    repeat (150) @(posedge clk);
    $display("covered %0d samples, %0d window closes, window lengths 1000/10/0/65535/1/%0d",
             samples_accepted, closes_predicted, len_list[4]);
    $display("history ring overwrote %0d entries; output held off once for 400 cycles",
             hist_overwrites);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
